FILE: hw/rtl/rbsat_pkg.sv
// Shared types and constants for the red-black append tree block.
// Used by rbsat_ctrl, rbsat_dp and red_black_sorted_append_tree_core.
package rbsat_pkg;

	localparam int NODE_SLOTS_DEF = 256;

	localparam logic [1:0] KIND_START  = 2'd0;
	localparam logic [1:0] KIND_APPEND = 2'd1;
	localparam logic [1:0] KIND_READ   = 2'd2;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_CLEAR,
		OP_INIT,
		OP_LINK,
		OP_RD_CUR,
		OP_GET_P,
		OP_GET_G,
		OP_GET_U,
		OP_REC_P,
		OP_ROT_P,
		OP_REC_U,
		OP_REC_G,
		OP_ROT1,
		OP_ROT2,
		OP_ROT3,
		OP_ROOT_BLACK,
		OP_RD_NODE,
		OP_RESULT
	} dp_op_t;

	typedef struct packed {
		logic [1:0] kind;
		logic       can_append;
		logic       last_valid;
		logic       par_valid;
		logic       black;
		logic       u_red;
	} dp_status_t;

endpackage

FILE: hw/rtl/rbsat_dp.sv
// Datapath: node link and color memories, root, rightmost node, membership bits
// and the working pointers of the insertion repair. Depends on rbsat_pkg.
module rbsat_dp import rbsat_pkg::*; #(
	parameter int NODE_SLOTS = NODE_SLOTS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  dp_op_t       op,
	input  logic [1:0]   kind,
	input  logic [7:0]   node,
	output dp_status_t   status,
	output logic [7:0]   root_node,
	output logic         root_valid,
	output logic [7:0]   left_node,
	output logic         left_valid,
	output logic [7:0]   right_node,
	output logic         right_valid,
	output logic         node_black
);

	localparam int AW = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
	localparam int NW = (AW > 8) ? AW : 8;

	logic [AW:0] left_mem [NODE_SLOTS];
	logic [AW:0] right_mem [NODE_SLOTS];
	logic [AW:0] par_mem [NODE_SLOTS];
	logic        color_mem [NODE_SLOTS];

	logic [AW:0] left_rd_q, right_rd_q, par_rd_q;
	logic        color_rd_q;

	logic [1:0]      kind_q;
	logic [AW-1:0]   slot_q;
	logic            in_range_q;
	logic [AW:0]     root_q, rmost_q, last_q, u_q, up_q;
	logic [AW-1:0]   cur_q, p_q, g_q;
	logic [NODE_SLOTS-1:0] member_q;

	logic [AW-1:0] raddr;
	logic          l_we, r_we, p_we, c_we;
	logic [AW-1:0] l_wa, r_wa, p_wa, c_wa;
	logic [AW:0]   l_wd, r_wd, p_wd;
	logic          c_wd;
	logic [NW-1:0] node_w;
	logic          show;

	assign node_w = NW'(node);
	assign show = in_range_q && member_q[slot_q] &&
		(kind_q == KIND_APPEND || kind_q == KIND_READ);

	assign status.kind       = kind_q;
	assign status.can_append = in_range_q && !member_q[slot_q];
	assign status.last_valid = last_q[AW];
	assign status.par_valid  = par_rd_q[AW];
	assign status.black      = color_rd_q;
	assign status.u_red      = u_q[AW] && !color_rd_q;

	always_comb begin
		raddr = slot_q;
		l_we = 1'b0; r_we = 1'b0; p_we = 1'b0; c_we = 1'b0;
		l_wa = slot_q; r_wa = slot_q; p_wa = slot_q; c_wa = slot_q;
		l_wd = '0; r_wd = '0; p_wd = '0; c_wd = 1'b0;
		unique case (op)
			OP_INIT: begin
				l_we = 1'b1; r_we = 1'b1; c_we = 1'b1; p_we = 1'b1;
				p_wd = rmost_q;
			end
			OP_LINK: begin
				r_we = 1'b1; r_wa = last_q[AW-1:0]; r_wd = {1'b1, slot_q};
			end
			OP_RD_CUR: raddr = cur_q;
			OP_GET_P, OP_GET_G: raddr = par_rd_q[AW-1:0];
			OP_GET_U: raddr = left_rd_q[AW-1:0];
			OP_REC_P: begin
				c_we = 1'b1; c_wa = p_q; c_wd = 1'b1;
			end
			OP_ROT_P: begin
				c_we = 1'b1; c_wa = p_q; c_wd = 1'b1; raddr = p_q;
			end
			OP_REC_U: begin
				c_we = 1'b1; c_wa = u_q[AW-1:0]; c_wd = 1'b1;
			end
			OP_REC_G: begin
				c_we = 1'b1; c_wa = g_q; c_wd = 1'b0;
			end
			OP_ROT1: begin
				c_we = 1'b1; c_wa = g_q; c_wd = 1'b0;
				r_we = 1'b1; r_wa = g_q; r_wd = left_rd_q;
				p_we = left_rd_q[AW]; p_wa = left_rd_q[AW-1:0]; p_wd = {1'b1, g_q};
			end
			OP_ROT2: begin
				p_we = 1'b1; p_wa = p_q; p_wd = up_q;
				r_we = up_q[AW]; r_wa = up_q[AW-1:0]; r_wd = {1'b1, p_q};
			end
			OP_ROT3: begin
				l_we = 1'b1; l_wa = p_q; l_wd = {1'b1, g_q};
				p_we = 1'b1; p_wa = g_q; p_wd = {1'b1, p_q};
			end
			OP_ROOT_BLACK: begin
				c_we = 1'b1; c_wa = root_q[AW-1:0]; c_wd = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (l_we) left_mem[l_wa] <= l_wd;
		if (r_we) right_mem[r_wa] <= r_wd;
		if (p_we) par_mem[p_wa] <= p_wd;
		if (c_we) color_mem[c_wa] <= c_wd;
		left_rd_q  <= left_mem[raddr];
		right_rd_q <= right_mem[raddr];
		par_rd_q   <= par_mem[raddr];
		color_rd_q <= color_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			member_q <= '0;
			root_q   <= '0;
			rmost_q  <= '0;
		end else begin
			case (op)
				OP_CLEAR: begin
					member_q <= '0;
					root_q   <= '0;
					rmost_q  <= '0;
				end
				OP_INIT: begin
					member_q[slot_q] <= 1'b1;
					rmost_q <= {1'b1, slot_q};
					if (!rmost_q[AW]) root_q <= {1'b1, slot_q};
				end
				OP_ROT2: if (!up_q[AW]) root_q <= {1'b1, p_q};
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_ACCEPT: begin
				kind_q     <= kind;
				slot_q     <= node_w[AW-1:0];
				in_range_q <= (32'(node) < NODE_SLOTS);
			end
			OP_INIT: begin
				last_q <= rmost_q;
				cur_q  <= slot_q;
			end
			OP_GET_P: p_q <= par_rd_q[AW-1:0];
			OP_GET_G: g_q <= par_rd_q[AW-1:0];
			OP_GET_U: begin
				u_q  <= left_rd_q;
				up_q <= par_rd_q;
			end
			OP_REC_G: cur_q <= g_q;
			OP_RESULT: begin
				root_node   <= 8'(NW'(root_q[AW-1:0]));
				root_valid  <= root_q[AW];
				left_node   <= show ? 8'(NW'(left_rd_q[AW-1:0])) : 8'd0;
				left_valid  <= show & left_rd_q[AW];
				right_node  <= show ? 8'(NW'(right_rd_q[AW-1:0])) : 8'd0;
				right_valid <= show & right_rd_q[AW];
				node_black  <= show & color_rd_q;
			end
			default: ;
		endcase
	end

endmodule

FILE: hw/rtl/rbsat_ctrl.sv
// Controller: sequences accept, append, insertion repair and node read.
// Depends on rbsat_pkg; drives rbsat_dp through op codes.
module rbsat_ctrl import rbsat_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output dp_op_t     op,
	output logic       busy,
	output logic       done
);

	typedef enum logic [15:0] {
		S_IDLE = 16'h0001,
		S_DISP = 16'h0002,
		S_APP1 = 16'h0004,
		S_APP2 = 16'h0008,
		S_RCUR = 16'h0010,
		S_GETP = 16'h0020,
		S_GETG = 16'h0040,
		S_GETU = 16'h0080,
		S_CHKU = 16'h0100,
		S_RECU = 16'h0200,
		S_RECG = 16'h0400,
		S_ROT1 = 16'h0800,
		S_ROT2 = 16'h1000,
		S_ROT3 = 16'h2000,
		S_ROOT = 16'h4000,
		S_RDN  = 16'h8000
	} state_t;

	state_t state_q, state_d;
	logic   res_q;

	assign busy = (state_q != S_IDLE) || res_q;

	always_comb begin
		state_d = state_q;
		op = OP_NOP;
		unique case (state_q)
			S_IDLE: if (start && !res_q) begin
				op = OP_ACCEPT; state_d = S_DISP;
			end
			S_DISP: begin
				if (status.kind == KIND_START) begin
					op = OP_CLEAR; state_d = S_RDN;
				end else if (status.kind == KIND_APPEND && status.can_append)
					state_d = S_APP1;
				else
					state_d = S_RDN;
			end
			S_APP1: begin op = OP_INIT; state_d = S_APP2; end
			S_APP2: begin
				if (status.last_valid) op = OP_LINK;
				state_d = S_RCUR;
			end
			S_RCUR: begin op = OP_RD_CUR; state_d = S_GETP; end
			S_GETP: begin
				if (!status.par_valid) state_d = S_ROOT;
				else begin op = OP_GET_P; state_d = S_GETG; end
			end
			S_GETG: begin
				if (status.black || !status.par_valid) state_d = S_ROOT;
				else begin op = OP_GET_G; state_d = S_GETU; end
			end
			S_GETU: begin op = OP_GET_U; state_d = S_CHKU; end
			S_CHKU: begin
				if (status.u_red) begin op = OP_REC_P; state_d = S_RECU; end
				else begin op = OP_ROT_P; state_d = S_ROT1; end
			end
			S_RECU: begin op = OP_REC_U; state_d = S_RECG; end
			S_RECG: begin op = OP_REC_G; state_d = S_RCUR; end
			S_ROT1: begin op = OP_ROT1; state_d = S_ROT2; end
			S_ROT2: begin op = OP_ROT2; state_d = S_ROT3; end
			S_ROT3: begin op = OP_ROT3; state_d = S_ROOT; end
			S_ROOT: begin op = OP_ROOT_BLACK; state_d = S_RDN; end
			S_RDN: begin op = OP_RD_NODE; state_d = S_IDLE; end
			default: state_d = S_IDLE;
		endcase
		if (res_q) op = OP_RESULT;
	end

	// result capture runs in the cycle after the node read, then strobes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_q   <= 1'b0;
			done    <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= (state_q == S_RDN);
			done    <= res_q;
		end
	end

endmodule

FILE: hw/rtl/red_black_sorted_append_tree_core.sv
// Top level of the red-black append tree block.
// Instantiates rbsat_ctrl and rbsat_dp; depends on rbsat_pkg.
//
// Pulse start while busy is low to transfer one item (kind, node). Exactly one
// result follows, valid for the single cycle in which done is high; the
// receiver cannot stall it. An append of a new node runs the insertion repair
// before the result, with recolor steps and rotations that go through the one
// read and one write port of each node memory. Busy stays high from the
// transfer until done; the next transfer can be taken at the edge that ends
// the done cycle.
module red_black_sorted_append_tree_core import rbsat_pkg::*; #(
	parameter int NODE_SLOTS = NODE_SLOTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	output logic       done,
	input  logic [1:0] kind,
	input  logic [7:0] node,
	output logic [7:0] root_node,
	output logic       root_valid,
	output logic [7:0] left_node,
	output logic       left_valid,
	output logic [7:0] right_node,
	output logic       right_valid,
	output logic       node_black
);

	dp_op_t     op;
	dp_status_t status;

	rbsat_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .status(status),
		.op(op), .busy(busy), .done(done)
	);

	rbsat_dp #(.NODE_SLOTS(NODE_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .op(op), .kind(kind), .node(node),
		.status(status), .root_node(root_node), .root_valid(root_valid),
		.left_node(left_node), .left_valid(left_valid),
		.right_node(right_node), .right_valid(right_valid),
		.node_black(node_black)
	);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("busy not raised after transfer");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_empty_node: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !root_valid) |-> (!left_valid && !right_valid && !node_black))
		else $error("node shown in empty tree");

endmodule

FILE: sim/tb_red_black_sorted_append_tree_core.sv
// Testbench for red_black_sorted_append_tree_core: drives start/read/append
// transfers and checks each result against an in-bench red-black tree model.
// Depends on rbsat_pkg and the RTL of red_black_sorted_append_tree_core.
`timescale 1ns / 1ps

module tb_red_black_sorted_append_tree_core;
	import rbsat_pkg::*;

	localparam int SLOTS = NODE_SLOTS_DEF;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] node;
	} tree_op_t;

	typedef struct packed {
		logic [7:0] root_node;
		logic       root_valid;
		logic [7:0] left_node;
		logic       left_valid;
		logic [7:0] right_node;
		logic       right_valid;
		logic       node_black;
	} node_view_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [1:0] kind = '0;
	logic [7:0] node = '0;
	logic       busy, done;
	logic [7:0] root_node, left_node, right_node;
	logic       root_valid, left_valid, right_valid, node_black;

	red_black_sorted_append_tree_core i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
		.kind(kind), .node(node), .root_node(root_node), .root_valid(root_valid),
		.left_node(left_node), .left_valid(left_valid), .right_node(right_node),
		.right_valid(right_valid), .node_black(node_black)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// tree model; -1 means no link
	int  lnk_l[SLOTS], lnk_r[SLOTS], lnk_p[SLOTS];
	bit  blk[SLOTS], member[SLOTS];
	int  root_idx;

	tree_op_t   pending_ops[$];
	node_view_t expected_views[$];
	int         sender_idle_pct = 19;
	int         mismatch_count = 0;
	int         transfers = 0;
	int         views_checked = 0;
	int         quiet_cycles = 0;
	bit         stim_done = 0;

	function automatic void tree_clear();
		for (int i = 0; i < SLOTS; i++) begin
			lnk_l[i] = -1; lnk_r[i] = -1; lnk_p[i] = -1;
			blk[i] = 0; member[i] = 0;
		end
		root_idx = -1;
	endfunction

	function automatic void tree_relink(int old_top, int new_top);
		int up;
		up = lnk_p[old_top];
		lnk_p[new_top] = up;
		if (up < 0) root_idx = new_top;
		else if (lnk_l[up] == old_top) lnk_l[up] = new_top;
		else lnk_r[up] = new_top;
	endfunction

	function automatic void rotate_left(int p);
		int q;
		q = lnk_r[p];
		if (q < 0) return;
		lnk_r[p] = lnk_l[q];
		if (lnk_l[q] >= 0) lnk_p[lnk_l[q]] = p;
		tree_relink(p, q);
		lnk_l[q] = p;
		lnk_p[p] = q;
	endfunction

	function automatic void rotate_right(int p);
		int q;
		q = lnk_l[p];
		if (q < 0) return;
		lnk_l[p] = lnk_r[q];
		if (lnk_r[q] >= 0) lnk_p[lnk_r[q]] = p;
		tree_relink(p, q);
		lnk_r[q] = p;
		lnk_p[p] = q;
	endfunction

	function automatic bit is_red(int n);
		return n >= 0 && !blk[n];
	endfunction

	function automatic void tree_append(int x);
		int cur, last, p, g, u, pp, gg;
		if (member[x]) return;
		member[x] = 1;
		lnk_l[x] = -1; lnk_r[x] = -1; blk[x] = 0;
		last = -1;
		cur = root_idx;
		while (cur >= 0) begin
			last = cur;
			cur = lnk_r[cur];
		end
		lnk_p[x] = last;
		if (last < 0) root_idx = x;
		else lnk_r[last] = x;
		cur = x;
		for (int guard = 0; guard < SLOTS; guard++) begin
			p = lnk_p[cur];
			if (p < 0 || blk[p]) break;
			g = lnk_p[p];
			if (g < 0) break;
			if (p == lnk_l[g]) begin
				u = lnk_r[g];
				if (is_red(u)) begin
					blk[p] = 1; blk[u] = 1; blk[g] = 0; cur = g;
					continue;
				end
				if (cur == lnk_r[p]) begin
					cur = p;
					rotate_left(cur);
				end
				pp = lnk_p[cur];
				gg = pp >= 0 ? lnk_p[pp] : -1;
				if (gg < 0) break;
				blk[pp] = 1; blk[gg] = 0;
				rotate_right(gg);
			end else begin
				u = lnk_l[g];
				if (is_red(u)) begin
					blk[p] = 1; blk[u] = 1; blk[g] = 0; cur = g;
					continue;
				end
				if (cur == lnk_l[p]) begin
					cur = p;
					rotate_right(cur);
				end
				pp = lnk_p[cur];
				gg = pp >= 0 ? lnk_p[pp] : -1;
				if (gg < 0) break;
				blk[pp] = 1; blk[gg] = 0;
				rotate_left(gg);
			end
		end
		if (root_idx >= 0) blk[root_idx] = 1;
	endfunction

	function automatic node_view_t tree_apply(tree_op_t op);
		node_view_t v;
		bit show;
		int n;
		n = op.node;
		show = 0;
		v = '0;
		if (op.kind == KIND_START) tree_clear();
		else if (op.kind == KIND_APPEND || op.kind == KIND_READ) begin
			if (n < SLOTS) begin
				if (op.kind == KIND_APPEND) tree_append(n);
				show = member[n];
			end
		end
		v.root_valid = root_idx >= 0;
		v.root_node = root_idx >= 0 ? root_idx[7:0] : 8'd0;
		if (show) begin
			v.left_valid = lnk_l[n] >= 0;
			v.left_node = lnk_l[n] >= 0 ? lnk_l[n][7:0] : 8'd0;
			v.right_valid = lnk_r[n] >= 0;
			v.right_node = lnk_r[n] >= 0 ? lnk_r[n][7:0] : 8'd0;
			v.node_black = blk[n];
		end
		return v;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch at result %0d: %s got %0d expected %0d",
			views_checked, what, got, want);
		mismatch_count++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_views.push_back(tree_apply('{kind: kind, node: node}));
				transfers++;
			end
			if ((!start || !busy) && pending_ops.size() > 0 &&
					$urandom_range(99) >= sender_idle_pct) begin
				tree_op_t op;
				op = pending_ops.pop_front();
				start <= 1'b1;
				kind <= op.kind;
				node <= op.node;
			end else if (!start || !busy) begin
				start <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && done) begin
			node_view_t got, want;
			got = '{root_node, root_valid, left_node, left_valid,
				right_node, right_valid, node_black};
			if (expected_views.size() == 0) begin
				report_mismatch("unexpected result, pending count", 1, 0);
			end else begin
				want = expected_views.pop_front();
				if (got.root_node !== want.root_node)
					report_mismatch("root_node", got.root_node, want.root_node);
				if (got.root_valid !== want.root_valid)
					report_mismatch("root_valid", got.root_valid, want.root_valid);
				if (got.left_node !== want.left_node)
					report_mismatch("left_node", got.left_node, want.left_node);
				if (got.left_valid !== want.left_valid)
					report_mismatch("left_valid", got.left_valid, want.left_valid);
				if (got.right_node !== want.right_node)
					report_mismatch("right_node", got.right_node, want.right_node);
				if (got.right_valid !== want.right_valid)
					report_mismatch("right_valid", got.right_valid, want.right_valid);
				if (got.node_black !== want.node_black)
					report_mismatch("node_black", got.node_black, want.node_black);
			end
			views_checked++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (done || (start && !busy)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic void queue_op(logic [1:0] k, logic [7:0] n);
		pending_ops.push_back('{kind: k, node: n});
	endfunction

	// one tree: appends of fresh slots and of members mixed with reads of members and some noise
	task automatic queue_random_tree(int max_len);
		bit used[SLOTS];
		int members[$];
		int len, s;
		len = $urandom_range(max_len, (max_len + 1) / 2);
		queue_op(KIND_START, 8'($urandom));
		for (int i = 0; i < len; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					s = $urandom_range(SLOTS - 1);
					while (used[s]) s = (s + 1) % SLOTS;
					if (members.size() < SLOTS) begin
						used[s] = 1;
						members.push_back(s);
						queue_op(KIND_APPEND, 8'(s));
					end
				end
				6, 7: if (members.size() > 0)
					queue_op(KIND_READ,
						8'(members[$urandom_range(members.size() - 1)]));
				8: if (members.size() > 0)
					queue_op(KIND_APPEND,
						8'(members[$urandom_range(members.size() - 1)]));
				default: queue_op(KIND_SPARE, 8'($urandom));
			endcase
		end
		foreach (members[j]) if ($urandom_range(3) == 0) queue_op(KIND_READ, 8'(members[j]));
	endtask

	task automatic drain();
		wait (pending_ops.size() == 0);
		@(posedge clk);
		while (start || busy || expected_views.size() > 0) @(posedge clk);
	endtask

	initial begin
		tree_clear();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty tree, spare kind, extremes, rotations, repeats
		queue_op(KIND_START, 8'hFF);
		queue_op(KIND_SPARE, 8'h00);
		queue_op(KIND_APPEND, 8'h00);
		queue_op(KIND_APPEND, 8'hFF);
		queue_op(KIND_APPEND, 8'h55);
		queue_op(KIND_APPEND, 8'hAA);
		queue_op(KIND_APPEND, 8'h01);
		queue_op(KIND_APPEND, 8'h80);
		queue_op(KIND_APPEND, 8'h7F);
		queue_op(KIND_READ, 8'h00);
		queue_op(KIND_READ, 8'hFF);
		queue_op(KIND_READ, 8'h55);
		queue_op(KIND_READ, 8'hAA);
		queue_op(KIND_APPEND, 8'h55);
		queue_op(KIND_SPARE, 8'hFF);
		queue_op(KIND_START, 8'h00);
		queue_op(KIND_READ, 8'hFF);

		sender_idle_pct = 19;
		for (int t = 0; t < 12; t++) queue_random_tree(30);
		drain();  // sender holds off until all results are in
		sender_idle_pct = 83;
		for (int t = 0; t < 8; t++) queue_random_tree(30);
		queue_random_tree(150);
		drain();
		sender_idle_pct = 0;
		for (int t = 0; t < 9; t++) queue_random_tree(30);
		queue_random_tree(170);
		drain();
		repeat (100) @(posedge clk);

		$display("covered %0d transfers and %0d results over empty, growing and rebuilt trees",
			transfers, views_checked);
		if (mismatch_count == 0 && expected_views.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/rbsat_pkg.sv
hw/rtl/rbsat_dp.sv
hw/rtl/rbsat_ctrl.sv
hw/rtl/red_black_sorted_append_tree_core.sv
sim/tb_red_black_sorted_append_tree_core.sv
